// ===== rtl/b2da_pkg.sv =====
// shared types, constants and a helper function for the decimal digit converter
package b2da_pkg;

    localparam int VALUE_W = 32;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;
    localparam int STEP_W  = $clog2(VALUE_W);

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;
    typedef logic [STEP_W-1:0]  t_step;

    localparam t_char  ASCII_ZERO = 6'd48;
    localparam t_step  LAST_STEP  = t_step'(VALUE_W - 1);
    localparam t_digit ADJ_LIMIT  = 4'd5;
    localparam t_digit ADJ_ADD    = 4'd3;

    // add-3 correction of one bcd digit ahead of the shift
    function automatic t_digit add3(input t_digit d);
        t_digit r;
        r = (d >= ADJ_LIMIT) ? t_digit'(d + ADJ_ADD) : d;
        return r;
    endfunction

endpackage

// ===== rtl/b2da_dabble.sv =====
// bit-serial shift-and-add-3 converter, one input bit per cycle into a row of digit cells
module b2da_dabble #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [b2da_pkg::VALUE_W-1:0]    i_value,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0] o_bcd
);

    localparam int BCD_W = MAX_DIGITS * b2da_pkg::DIGIT_W;

    logic [b2da_pkg::VALUE_W-1:0] r_shift;
    logic [BCD_W-1:0]             r_bcd;
    logic [BCD_W-1:0]             n_bcd;
    logic [BCD_W-1:0]             w_adj;
    b2da_pkg::t_step              r_step;
    logic                         r_busy;
    logic                         r_done;

    // per-digit correction cells
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            w_adj[k*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
                b2da_pkg::add3(r_bcd[k*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W]);
        end
    end

    // shift the corrected row left, msb of the number enters at the bottom
    always_comb begin
        n_bcd = {w_adj[BCD_W-2:0], r_shift[b2da_pkg::VALUE_W-1]};
    end

    // step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= b2da_pkg::t_step'(r_step + 1'b1);
                if (r_step == b2da_pkg::LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // data shift registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_bcd   <= '0;
        end else if (r_busy) begin
            r_shift <= r_shift << 1;
            r_bcd   <= n_bcd;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== rtl/b2da_emit.sv =====
// digit shifter that drops leading zeros, then feeds the output register one character per cycle while not stalled
module b2da_emit #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_load,
    input  logic [MAX_DIGITS*b2da_pkg::DIGIT_W-1:0] i_bcd,
    input  logic                            i_stall,
    output logic                            o_busy,
    output logic                            o_valid,
    output b2da_pkg::t_char                 o_digit_char,
    output logic                            o_last
);

    localparam int BCD_W = MAX_DIGITS * b2da_pkg::DIGIT_W;
    localparam int LW    = $clog2(MAX_DIGITS + 1);

    logic [BCD_W-1:0]  r_dig;
    logic [LW-1:0]     r_left;
    logic              r_active;
    logic              r_seen;
    logic              r_valid;
    b2da_pkg::t_char   r_char;
    logic              r_last;
    b2da_pkg::t_digit  w_top;
    logic              w_one_left;
    logic              w_skip;
    logic              w_emit;

    // decide skip or emit for the digit at the top
    always_comb begin
        w_top      = r_dig[BCD_W-1 -: b2da_pkg::DIGIT_W];
        w_one_left = (r_left == LW'(1));
        w_skip     = r_active && !r_seen && (w_top == '0) && !w_one_left;
        w_emit     = r_active && !w_skip && (!r_valid || !i_stall);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_seen   <= 1'b0;
            r_valid  <= 1'b0;
            r_left   <= '0;
        end else begin
            if (i_load) begin
                r_active <= 1'b1;
                r_seen   <= 1'b0;
                r_left   <= LW'(MAX_DIGITS);
            end else if (w_skip || w_emit) begin
                r_left <= LW'(r_left - 1'b1);
                if (w_emit) begin
                    r_seen <= 1'b1;
                end
                if (w_emit && w_one_left) begin
                    r_active <= 1'b0;
                end
            end
            // output register, held while stalled
            if (w_emit) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // digit store and character register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dig <= i_bcd;
        end else if (w_skip || w_emit) begin
            r_dig <= r_dig << b2da_pkg::DIGIT_W;
        end
        if (w_emit) begin
            r_char <= b2da_pkg::ASCII_ZERO | b2da_pkg::t_char'(w_top);
            r_last <= w_one_left;
        end
    end

    assign o_busy       = r_active;
    assign o_valid      = r_valid;
    assign o_digit_char = r_char;
    assign o_last       = r_last;

endmodule

// ===== rtl/binary_to_decimal_ascii_digits.sv =====
// top level: unsigned 32-bit number in, ascii decimal digits out, most significant first
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_stall   i_value (32 bits)
//  output   out        o_valid / i_stall   o_digit_char (6 bits), o_last
//
// one number passes through the bit-serial digit row (32 shifts, one
// handover), then through the digit shifter, one step per leading zero
// dropped or digit sent, MAX_DIGITS steps in all, plus output stalls. o_stall
// is high while a number is converted or its digits are still queued; the
// last character may wait in the output register while the next number is
// taken in. reset: sync, active low.
module binary_to_decimal_ascii_digits #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [b2da_pkg::VALUE_W-1:0] i_value,
    output logic                         o_valid,
    input  logic                         i_stall,
    output b2da_pkg::t_char              o_digit_char,
    output logic                         o_last
);

    localparam int BCD_W = MAX_DIGITS * b2da_pkg::DIGIT_W;

    logic             w_start;
    logic             w_conv_busy;
    logic             w_conv_done;
    logic             w_emit_busy;
    logic [BCD_W-1:0] w_bcd;

    // input transfer only when both parts are free
    assign o_stall = w_conv_busy || w_conv_done || w_emit_busy;
    assign w_start = i_valid && !o_stall;

    b2da_dabble #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_value (i_value),
        .o_busy  (w_conv_busy),
        .o_done  (w_conv_done),
        .o_bcd   (w_bcd)
    );

    b2da_emit #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_conv_done),
        .i_bcd        (w_bcd),
        .i_stall      (i_stall),
        .o_busy       (w_emit_busy),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

endmodule

// ===== bench/binary_to_decimal_ascii_digits_tb.sv =====
// self-checking bench for the binary to decimal ascii digit converter
`timescale 1ns / 100ps

module binary_to_decimal_ascii_digits_tb;

    localparam int N_DIGITS    = 10;
    localparam int HALF_PERIOD = 6;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE      = 2 * (1 + b2da_pkg::VALUE_W + N_DIGITS);
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 50;
    localparam int MAX_REPORTS = 10;
    localparam int CYCLE_LIMIT = 400000;

    // one expected character of a number
    typedef struct {
        logic [b2da_pkg::VALUE_W-1:0] value;
        b2da_pkg::t_char              ch;
        logic                         last;
    } t_digit_exp;

    // decimal digit predictor and character scoreboard
    class digit_scoreboard #(int DIGITS = 10);
        t_digit_exp expected_q[$];
        int         values_noted;
        int         chars_checked;
        int         errors;

        // shift-and-add-3 conversion, digits queued most significant first
        function void note_value(input logic [b2da_pkg::VALUE_W-1:0] v);
            logic [b2da_pkg::DIGIT_W-1:0] bcd [DIGITS];
            logic [b2da_pkg::VALUE_W-1:0] sh;
            logic [b2da_pkg::DIGIT_W:0]   wide;
            logic                         carry;
            int                           top;
            t_digit_exp                   rec;
            for (int k = 0; k < DIGITS; k++) bcd[k] = '0;
            sh = v;
            repeat (b2da_pkg::VALUE_W) begin
                for (int k = 0; k < DIGITS; k++) begin
                    if (bcd[k] >= 4'd5) bcd[k] = bcd[k] + 4'd3;
                end
                carry = sh[b2da_pkg::VALUE_W-1];
                sh = sh << 1;
                // carries out of the top digit fall away
                for (int k = 0; k < DIGITS; k++) begin
                    wide   = {bcd[k], carry};
                    carry  = wide[b2da_pkg::DIGIT_W];
                    bcd[k] = wide[b2da_pkg::DIGIT_W-1:0];
                end
            end
            // leading zeros dropped, zero still gives one digit
            top = 0;
            for (int k = DIGITS - 1; k > 0; k--) begin
                if (top == 0 && bcd[k] != '0) top = k;
            end
            for (int k = top; k >= 0; k--) begin
                rec.value = v;
                rec.ch    = b2da_pkg::ASCII_ZERO + b2da_pkg::t_char'(bcd[k]);
                rec.last  = (k == 0);
                expected_q.push_back(rec);
            end
            values_noted++;
        endfunction

        function void check_char(input b2da_pkg::t_char ch, input logic last);
            t_digit_exp e;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] unexpected char %0d last %b, nothing pending",
                             $realtime, ch, last);
                return;
            end
            e = expected_q.pop_front();
            chars_checked++;
            if (ch !== e.ch || last !== e.last) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("[%0t] value %0d: expected char %0d last %b, got %0d last %b",
                             $realtime, e.value, e.ch, e.last, ch, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         i_valid = 1'b0;
    logic [b2da_pkg::VALUE_W-1:0] i_value = '0;
    logic                         i_stall = 1'b0;
    logic                         o_stall;
    logic                         o_valid;
    b2da_pkg::t_char              o_digit_char;
    logic                         o_last;

    digit_scoreboard #(N_DIGITS) sb = new;

    int send_pct  = 0;
    int recv_pct  = 0;
    bit hold_req  = 1'b0;
    int cycle_count = 0;
    int n_directed  = 0;

    logic [b2da_pkg::VALUE_W-1:0] directed_q[$] = '{
        32'd0, 32'd1, 32'd5, 32'd9, 32'd10, 32'd19, 32'd99, 32'd100, 32'd255,
        32'd999, 32'd1000, 32'd65535, 32'd99999999, 32'd100000000,
        32'd999999999, 32'd1000000000, 32'd2147483647, 32'd2147483648,
        32'd4294967295, 32'd4294967294, 32'h55555555, 32'hAAAAAAAA,
        32'd1234567890, 32'd3999999999
    };

    binary_to_decimal_ascii_digits #(.MAX_DIGITS(N_DIGITS)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_digit_char (o_digit_char),
        .o_last       (o_last)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // output side: random stall, or a long hold-off when requested
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                repeat (HOLD_CYCLES) begin
                    i_stall <= 1'b1;
                    @(negedge i_clk);
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_pct);
        end
    end

    // check each character transfer
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_char(o_digit_char, o_last);
    end

    // number near a power of ten, one either side
    function automatic logic [b2da_pkg::VALUE_W-1:0] near_pow10();
        logic [b2da_pkg::VALUE_W-1:0] p;
        int                           k;
        k = $urandom_range(0, 9);
        p = 1;
        repeat (k) p = p * 10;
        return p + $urandom_range(0, 2) - 1;
    endfunction

    // mix of full-width, narrowed and power-of-ten numbers
    function automatic logic [b2da_pkg::VALUE_W-1:0] rand_value();
        int w;
        unique case ($urandom_range(0, 7))
            0: return near_pow10();
            1, 2, 3: return $urandom;
            default: begin
                w = $urandom_range(1, b2da_pkg::VALUE_W);
                return $urandom >> (b2da_pkg::VALUE_W - w);
            end
        endcase
    endfunction

    // present one number and hold it until the transfer
    task automatic offer(input logic [b2da_pkg::VALUE_W-1:0] v);
        i_valid <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_value(v);
        @(negedge i_clk);
    endtask

    task automatic sender_idle();
        while ($urandom_range(0, 99) < send_pct) begin
            i_valid <= 1'b0;
            i_value <= $urandom;
            @(negedge i_clk);
        end
    endtask

    // stop offering until every expected character is out
    task automatic drain_pause();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic random_phase(input int s_pct, input int r_pct, input bit pressure);
        send_pct = s_pct;
        recv_pct = r_pct;
        for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (pressure && i == 20) hold_req = 1'b1;
            if (pressure && i == 35) drain_pause();
            offer(rand_value());
            sender_idle();
        end
        drain_pause();
    endtask

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d characters pending", cycle_count,
                 sb.pending());
        $display("binary_to_decimal_ascii_digits_tb: FAIL");
        $finish;
    end

    // stimulus
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed corner numbers
        send_pct = 17;
        recv_pct = 81;
        foreach (directed_q[i]) begin
            offer(directed_q[i]);
            sender_idle();
        end
        n_directed = directed_q.size();
        drain_pause();

        random_phase(17, 81, 1'b1);
        random_phase(81, 17, 1'b0);
        random_phase(0, 0, 1'b0);

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        $display("converted %0d numbers (%0d corner cases), checked %0d digit characters",
                 sb.values_noted, n_directed, sb.chars_checked);
        $display("idle mixes 17/81, 81/17 and none, one %0d-cycle output hold, %0d errors",
                 HOLD_CYCLES, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("binary_to_decimal_ascii_digits_tb: PASS");
        end else begin
            $display("binary_to_decimal_ascii_digits_tb: FAIL");
        end
        $finish;
    end

endmodule
